FILE: rtl/int64_divider_quotient_remainder_core_defines.svh
// assertion macros for the integer divider core
`ifndef INT64_DIVIDER_QUOTIENT_REMAINDER_CORE_DEFINES_SVH
`define INT64_DIVIDER_QUOTIENT_REMAINDER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off during rst
`define I64DQR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i64dqr assertion failed");
// next-cycle implication, sampled on clk, off during rst
`define I64DQR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i64dqr assertion failed");
`else
`define I64DQR_ASSERT_NOW(label, ante, cons)
`define I64DQR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/i64dqr_pkg.sv
// shared constants and types of the integer divider
package i64dqr_pkg;

  // width of the dividend, divisor, quotient and remainder ports
  localparam int unsigned FIELD_W = 64;

  // default working width of the divider
  localparam int unsigned DATA_WIDTH_DEFAULT = 64;

  typedef enum logic {
    CMD_UNSIGNED = 1'b0,
    CMD_SIGNED   = 1'b1
  } command_t;

endpackage

FILE: rtl/i64dqr_negate.sv
// conditional two's complement negation of one operand
module i64dqr_negate #(
  parameter int unsigned W = i64dqr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic         en,
  input  logic [W-1:0] x,
  output logic [W-1:0] y
);
  import i64dqr_pkg::*;

  assign y = en ? (~x + W'(1)) : x;

endmodule

FILE: rtl/i64dqr_step.sv
// one restoring shift-subtract step of the divider
module i64dqr_step #(
  parameter int unsigned W = i64dqr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic [W-1:0] rem,
  input  logic         next_bit,
  input  logic [W-1:0] div,
  output logic [W-1:0] rem_next,
  output logic         qbit
);
  import i64dqr_pkg::*;

  logic [W:0]   shifted;
  logic [W+1:0] trial;

  // partial remainder keeps the bit shifted out on top
  assign shifted  = {rem, next_bit};
  assign trial    = {1'b0, shifted} - {2'b00, div};
  assign qbit     = ~trial[W+1];
  assign rem_next = qbit ? trial[W-1:0] : shifted[W-1:0];

endmodule

FILE: rtl/int64_divider_quotient_remainder_core.sv
// top level of the iterative integer divider
//
// usage: one divide per transfer on the input channel (in_valid/in_ready)
// carrying command, dividend and divisor. command selects unsigned or
// signed two's complement division. only the low DATA_WIDTH bits of the
// operands are used; results are zero-extended to the 64-bit ports.
// one result transfer (out_valid/out_ready) returns quotient and remainder.
// signed quotients truncate toward zero, the remainder takes the sign of
// the dividend, the most negative value by minus one wraps, and a zero
// divisor gives quotient 0 with the dividend as remainder.
// steps after the input transfer: sign preparation, one quotient bit per
// cycle in the shared shift-subtract unit, sign correction; out_valid rises
// with the corrected result.
// one item at a time: the single subtractor works on one item, and no new
// item is taken until the current one reaches the output register.
// in_ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next item is accepted meanwhile.
// if the receiver stalls, the following result holds in the correction
// state until the output register frees up.
// reset (rst, synchronous) returns to idle and drops out_valid.
module int64_divider_quotient_remainder_core #(
  parameter int unsigned DATA_WIDTH = i64dqr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [i64dqr_pkg::FIELD_W-1:0] dividend,
  input  logic [i64dqr_pkg::FIELD_W-1:0] divisor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i64dqr_pkg::FIELD_W-1:0] quotient,
  output logic [i64dqr_pkg::FIELD_W-1:0] remainder
);
  import i64dqr_pkg::*;

`include "int64_divider_quotient_remainder_core_defines.svh"

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIX  = 4'b1000
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;

  // captured operands
  logic          cmd_r;
  logic [W-1:0]  a_raw;
  logic [W-1:0]  b_raw;

  // working registers: divisor magnitude, partial remainder, and the
  // dividend magnitude that turns into the quotient as bits shift in
  logic [W-1:0]  div_mag;
  logic [W-1:0]  rem;
  logic [W-1:0]  qa;
  logic          zero_div;
  logic          neg_q;
  logic          neg_r;

  logic          is_signed;
  logic          a_neg;
  logic          b_neg;

  // shared negators: operand magnitudes in prep, result signs in fix
  logic          neg0_en;
  logic          neg1_en;
  logic [W-1:0]  neg0_x;
  logic [W-1:0]  neg1_x;
  logic [W-1:0]  neg0_y;
  logic [W-1:0]  neg1_y;

  logic [W-1:0]  step_rem;
  logic          step_qbit;

  logic [W-1:0]  q_fin;
  logic [W-1:0]  r_fin;

  assign in_ready  = (state == ST_IDLE);

  assign is_signed = (command_t'(cmd_r) == CMD_SIGNED);
  assign a_neg     = is_signed && a_raw[W-1];
  assign b_neg     = is_signed && b_raw[W-1];

  assign neg0_en = (state == ST_PREP) ? a_neg : neg_q;
  assign neg1_en = (state == ST_PREP) ? b_neg : neg_r;
  assign neg0_x  = (state == ST_PREP) ? a_raw : qa;
  assign neg1_x  = (state == ST_PREP) ? b_raw : rem;

  i64dqr_negate #(.W(W)) u_neg0 (
    .en (neg0_en),
    .x  (neg0_x),
    .y  (neg0_y)
  );

  i64dqr_negate #(.W(W)) u_neg1 (
    .en (neg1_en),
    .x  (neg1_x),
    .y  (neg1_y)
  );

  // one quotient bit per cycle, dividend bits fed from the top of qa
  i64dqr_step #(.W(W)) u_step (
    .rem      (rem),
    .next_bit (qa[W-1]),
    .div      (div_mag),
    .rem_next (step_rem),
    .qbit     (step_qbit)
  );

  // zero divisor overrides the restoring result
  assign q_fin = zero_div ? '0 : neg0_y;
  assign r_fin = zero_div ? a_raw : neg1_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // in fix the output register is reloaded in the same cycle instead
      if (out_valid && out_ready && state != ST_FIX) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r <= command;
            a_raw <= dividend[W-1:0];
            b_raw <= divisor[W-1:0];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          qa       <= neg0_y;
          div_mag  <= neg1_y;
          rem      <= '0;
          zero_div <= (b_raw == '0);
          neg_q    <= a_neg ^ b_neg;
          neg_r    <= a_neg;
          cnt      <= CW'(W - 1);
          state    <= ST_RUN;
        end
        ST_RUN: begin
          rem <= step_rem;
          qa  <= {qa[W-2:0], step_qbit};
          if (cnt == '0) begin
            state <= ST_FIX;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        ST_FIX: begin
          // wait here while the previous result is still unclaimed
          if (!out_valid || out_ready) begin
            quotient  <= FIELD_W'(q_fin);
            remainder <= FIELD_W'(r_fin);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an accepted item always starts with sign preparation
  `I64DQR_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, state == ST_PREP)
  // no new item while one is being divided
  `I64DQR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // last iteration hands over to the correction step
  `I64DQR_ASSERT_NEXT(a_run_end, state == ST_RUN && cnt == '0, state == ST_FIX)
  // a new result only ever comes out of the correction step
  `I64DQR_ASSERT_NOW(a_result_from_fix, $rose(out_valid), $past(state) == ST_FIX)

endmodule
